// ----- rtl/core/ole_pkg.sv -----
// Shared constants, codes and controller/datapath command types for the
// ordered list engine. No dependencies.
package ole_pkg;

   // list geometry
   localparam int DEPTH = 16;
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   // beat field widths
   localparam int CMD_W    = 3;
   localparam int VALUE_W  = 32;
   localparam int POS_W    = 4;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;

   // width for comparing a request position against the length
   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

   // command codes
   localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd0;
   localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd1;
   localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd2;
   localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_REMOVE_AT  = 3'd4;
   localparam logic [CMD_W-1:0] CMD_REMOVE_VAL = 3'd5;

   // status codes
   localparam logic [STATUS_W-1:0] STAT_OK   = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_MISS = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_FULL = 2'd2;

   typedef enum logic [2:0] {
      PTR_HOLD, PTR_ZERO, PTR_POS, PTR_LAST, PTR_INC, PTR_DEC
   } ptr_sel_type;

   typedef enum logic [1:0] {
      RD_PTR, RD_NEXT, RD_SKIP, RD_PREV
   } rd_sel_type;

   typedef enum logic [1:0] {
      WA_PTR, WA_NEXT, WA_LEN, WA_ZERO
   } wa_sel_type;

   typedef enum logic {
      WD_VALUE, WD_RDATA
   } wd_sel_type;

   typedef struct packed {
      logic                load;
      ptr_sel_type         ptr_sel;
      rd_sel_type          rd_sel;
      logic                wr_en;
      wa_sel_type          wa_sel;
      wd_sel_type          wd_sel;
      logic                take;
      logic                len_inc;
      logic                len_dec;
      logic                set_status;
      logic [STATUS_W-1:0] status;
      logic                rsp_load;
   } dp_cmd_type;

   typedef struct packed {
      logic [CMD_W-1:0] cmd;
      logic             empty;
      logic             full;
      logic             pos_ok;
      logic             match;
      logic             ptr_zero;
      logic             ptr_last;
      logic             ptr_penult;
   } dp_stat_type;

endpackage

// ----- rtl/core/ole_if.sv -----
// Valid/ready channel interfaces for command and result beats.
// Depends on ole_pkg for field widths.
interface ole_req_if;
   logic                                valid;
   logic                                ready;
   logic [ole_pkg::CMD_W-1:0]           cmd;
   logic signed [ole_pkg::VALUE_W-1:0]  value;
   logic [ole_pkg::POS_W-1:0]           position;

   modport source (output valid, cmd, value, position, input ready);
   modport sink   (input valid, cmd, value, position, output ready);
endinterface

interface ole_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [ole_pkg::STATUS_W-1:0]        status;
   logic signed [ole_pkg::VALUE_W-1:0]  removed_value;
   logic [ole_pkg::COUNT_W-1:0]         entry_count;

   modport source (output valid, status, removed_value, entry_count, input ready);
   modport sink   (input valid, status, removed_value, entry_count, output ready);
endinterface

// ----- rtl/core/ole_datapath.sv -----
// Datapath: entry memory, length, walk pointer and result register.
// Depends on ole_pkg; driven by ole_ctrl through dp_cmd_type.
module ole_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [ole_pkg::CMD_W-1:0]           req_cmd,
   input  logic signed [ole_pkg::VALUE_W-1:0]  req_value,
   input  logic [ole_pkg::POS_W-1:0]           req_position,
   input  ole_pkg::dp_cmd_type                 dp_cmd,
   output ole_pkg::dp_stat_type                dp_stat,
   output logic [ole_pkg::STATUS_W-1:0]        rsp_status,
   output logic signed [ole_pkg::VALUE_W-1:0]  rsp_removed_value,
   output logic [ole_pkg::COUNT_W-1:0]         rsp_entry_count
);
   import ole_pkg::*;

   logic [VALUE_W-1:0]  mem [DEPTH];

   logic [CNT_W-1:0]    len_ff, len_in;
   logic [IDX_W-1:0]    ptr_ff, ptr_in;
   logic [CMD_W-1:0]    cmd_ff;
   logic [VALUE_W-1:0]  value_ff;
   logic [POS_W-1:0]    pos_ff;
   logic [VALUE_W-1:0]  rdata_ff;
   logic [VALUE_W-1:0]  removed_ff;
   logic [STATUS_W-1:0] status_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [VALUE_W-1:0]  rsp_removed_ff;
   logic [COUNT_W-1:0]  rsp_count_ff;

   logic [CNT_W-1:0]    len_m1;
   logic [CNT_W:0]      ra_wide, wa_wide;
   logic [IDX_W-1:0]    rd_addr, wr_addr;
   logic [VALUE_W-1:0]  wr_data;

   assign len_m1 = len_ff - CNT_W'(1);

   // status back to the controller
   assign dp_stat.cmd        = cmd_ff;
   assign dp_stat.empty      = (len_ff == '0);
   assign dp_stat.full       = (len_ff == CNT_W'(DEPTH));
   assign dp_stat.pos_ok     = (CMP_W'(pos_ff) < CMP_W'(len_ff));
   assign dp_stat.match      = (rdata_ff == value_ff);
   assign dp_stat.ptr_zero   = (ptr_ff == '0);
   assign dp_stat.ptr_last   = (CNT_W'(ptr_ff) == len_m1);
   assign dp_stat.ptr_penult = ((CNT_W + 1)'(ptr_ff) + (CNT_W + 1)'(2) ==
                                (CNT_W + 1)'(len_ff));

   always_comb begin
      case (dp_cmd.rd_sel)
         RD_PTR:  ra_wide = (CNT_W + 1)'(ptr_ff);
         RD_NEXT: ra_wide = (CNT_W + 1)'(ptr_ff) + (CNT_W + 1)'(1);
         RD_SKIP: ra_wide = (CNT_W + 1)'(ptr_ff) + (CNT_W + 1)'(2);
         RD_PREV: ra_wide = (CNT_W + 1)'(ptr_ff) - (CNT_W + 1)'(1);
         default: ra_wide = '0;
      endcase
      // reads past the end feed nothing; keep the index in range
      rd_addr = (ra_wide < (CNT_W + 1)'(DEPTH)) ? IDX_W'(ra_wide) : '0;
   end

   always_comb begin
      case (dp_cmd.wa_sel)
         WA_PTR:  wa_wide = (CNT_W + 1)'(ptr_ff);
         WA_NEXT: wa_wide = (CNT_W + 1)'(ptr_ff) + (CNT_W + 1)'(1);
         WA_LEN:  wa_wide = (CNT_W + 1)'(len_ff);
         WA_ZERO: wa_wide = '0;
         default: wa_wide = '0;
      endcase
      wr_addr = IDX_W'(wa_wide);
      wr_data = (dp_cmd.wd_sel == WD_VALUE) ? value_ff : rdata_ff;
   end

   always_comb begin
      case (dp_cmd.ptr_sel)
         PTR_HOLD: ptr_in = ptr_ff;
         PTR_ZERO: ptr_in = '0;
         PTR_POS:  ptr_in = IDX_W'(CMP_W'(pos_ff));
         PTR_LAST: ptr_in = IDX_W'(len_m1);
         PTR_INC:  ptr_in = ptr_ff + IDX_W'(1);
         PTR_DEC:  ptr_in = ptr_ff - IDX_W'(1);
         default:  ptr_in = ptr_ff;
      endcase
      len_in = len_ff;
      if (dp_cmd.len_inc) begin
         len_in = len_ff + CNT_W'(1);
      end else if (dp_cmd.len_dec) begin
         len_in = len_m1;
      end
   end

   // entry memory: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (dp_cmd.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rdata_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= '0;
      end else begin
         len_ff <= len_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff <= ptr_in;
      if (dp_cmd.load) begin
         cmd_ff     <= req_cmd;
         value_ff   <= req_value;
         pos_ff     <= req_position;
         removed_ff <= '0;
         status_ff  <= STAT_OK;
      end else begin
         if (dp_cmd.take) begin
            removed_ff <= rdata_ff;
         end
         if (dp_cmd.set_status) begin
            status_ff <= dp_cmd.status;
         end
      end
      if (dp_cmd.rsp_load) begin
         rsp_status_ff  <= status_ff;
         rsp_removed_ff <= removed_ff;
         rsp_count_ff   <= COUNT_W'(len_ff);
      end
   end

   assign rsp_status        = rsp_status_ff;
   assign rsp_removed_value = rsp_removed_ff;
   assign rsp_entry_count   = rsp_count_ff;

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= CNT_W'(DEPTH))
      else $error("list length above depth");

   a_len_step: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.len_inc |=> len_ff == $past(len_ff) + CNT_W'(1))
      else $error("length did not grow by one");

   a_wr_range: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.wr_en |-> wa_wide < (CNT_W + 1)'(DEPTH))
      else $error("write beyond entry memory");

endmodule

// ----- rtl/core/ole_ctrl.sv -----
// Controller: command sequencing over the entry memory and result handshake.
// Depends on ole_pkg; drives ole_datapath via dp_cmd_type.
module ole_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output ole_pkg::dp_cmd_type  dp_cmd,
   input  ole_pkg::dp_stat_type dp_stat
);
   import ole_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_DISPATCH, S_UP_FILL, S_UP_MOVE, S_UP_HEAD,
      S_FILL, S_TAKE, S_DN_MOVE, S_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;
   logic      hit;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign hit       = (dp_stat.cmd != CMD_REMOVE_VAL) || dp_stat.match;

   always_comb begin
      dp_cmd            = '0;
      dp_cmd.ptr_sel    = PTR_HOLD;
      dp_cmd.rd_sel     = RD_PTR;
      dp_cmd.wa_sel     = WA_PTR;
      dp_cmd.wd_sel     = WD_RDATA;
      dp_cmd.status     = STAT_OK;
      state_in          = state_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               dp_cmd.load = 1'b1;
               state_in    = S_DISPATCH;
            end
         end

         S_DISPATCH: begin
            state_in = S_DONE;
            case (dp_stat.cmd)
               CMD_PUSH_BACK: begin
                  if (dp_stat.full) begin
                     dp_cmd.set_status = 1'b1;
                     dp_cmd.status     = STAT_FULL;
                  end else begin
                     dp_cmd.wr_en   = 1'b1;
                     dp_cmd.wa_sel  = WA_LEN;
                     dp_cmd.wd_sel  = WD_VALUE;
                     dp_cmd.len_inc = 1'b1;
                  end
               end
               CMD_PUSH_FRONT: begin
                  if (dp_stat.full) begin
                     dp_cmd.set_status = 1'b1;
                     dp_cmd.status     = STAT_FULL;
                  end else if (dp_stat.empty) begin
                     dp_cmd.wr_en   = 1'b1;
                     dp_cmd.wa_sel  = WA_ZERO;
                     dp_cmd.wd_sel  = WD_VALUE;
                     dp_cmd.len_inc = 1'b1;
                  end else begin
                     dp_cmd.ptr_sel = PTR_LAST;
                     state_in       = S_UP_FILL;
                  end
               end
               CMD_POP_BACK, CMD_POP_FRONT, CMD_REMOVE_VAL: begin
                  if (dp_stat.empty) begin
                     dp_cmd.set_status = 1'b1;
                     dp_cmd.status     = STAT_MISS;
                  end else begin
                     dp_cmd.ptr_sel = (dp_stat.cmd == CMD_POP_BACK) ? PTR_LAST : PTR_ZERO;
                     state_in       = S_FILL;
                  end
               end
               CMD_REMOVE_AT: begin
                  if (!dp_stat.pos_ok) begin
                     dp_cmd.set_status = 1'b1;
                     dp_cmd.status     = STAT_MISS;
                  end else begin
                     dp_cmd.ptr_sel = PTR_POS;
                     state_in       = S_FILL;
                  end
               end
               default: begin
                  // unused codes: no change, plain ok result
               end
            endcase
         end

         // shift up toward the back, last entry first
         S_UP_FILL: begin
            dp_cmd.rd_sel = RD_PTR;
            state_in      = S_UP_MOVE;
         end

         S_UP_MOVE: begin
            dp_cmd.wr_en  = 1'b1;
            dp_cmd.wa_sel = WA_NEXT;
            dp_cmd.wd_sel = WD_RDATA;
            dp_cmd.rd_sel = RD_PREV;
            if (dp_stat.ptr_zero) begin
               state_in = S_UP_HEAD;
            end else begin
               dp_cmd.ptr_sel = PTR_DEC;
            end
         end

         S_UP_HEAD: begin
            dp_cmd.wr_en   = 1'b1;
            dp_cmd.wa_sel  = WA_ZERO;
            dp_cmd.wd_sel  = WD_VALUE;
            dp_cmd.len_inc = 1'b1;
            state_in       = S_DONE;
         end

         S_FILL: begin
            dp_cmd.rd_sel = RD_PTR;
            state_in      = S_TAKE;
         end

         // read data is the entry at ptr; remove-by-value keeps scanning
         S_TAKE: begin
            if (hit) begin
               dp_cmd.take = 1'b1;
               if (dp_stat.ptr_last) begin
                  dp_cmd.len_dec = 1'b1;
                  state_in       = S_DONE;
               end else begin
                  dp_cmd.rd_sel = RD_NEXT;
                  state_in      = S_DN_MOVE;
               end
            end else if (dp_stat.ptr_last) begin
               dp_cmd.set_status = 1'b1;
               dp_cmd.status     = STAT_MISS;
               state_in          = S_DONE;
            end else begin
               dp_cmd.ptr_sel = PTR_INC;
               dp_cmd.rd_sel  = RD_NEXT;
            end
         end

         // close the gap: entry ptr+1 moves to ptr
         S_DN_MOVE: begin
            dp_cmd.wr_en   = 1'b1;
            dp_cmd.wa_sel  = WA_PTR;
            dp_cmd.wd_sel  = WD_RDATA;
            dp_cmd.rd_sel  = RD_SKIP;
            dp_cmd.ptr_sel = PTR_INC;
            if (dp_stat.ptr_penult) begin
               dp_cmd.len_dec = 1'b1;
               state_in       = S_DONE;
            end
         end

         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               dp_cmd.rsp_load = 1'b1;
               state_in        = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_valid_in = rsp_valid_ff;
      if (dp_cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_accept_dispatch: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == S_DISPATCH)
      else $error("accepted beat not dispatched");

   a_head_after_shift: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_UP_HEAD |-> $past(state_ff) == S_UP_MOVE)
      else $error("front insert without shift");

   a_done_waits: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DONE && rsp_valid_ff && !rsp_ready |=> state_ff == S_DONE)
      else $error("result overwritten while waiting");

   a_one_len_change: assert property (@(posedge clock) disable iff (reset)
      !(dp_cmd.len_inc && dp_cmd.len_dec))
      else $error("length grown and shrunk at once");

endmodule

// ----- rtl/core/ordered_list_engine_top.sv -----
// Top level of the ordered list engine: controller plus datapath.
// Depends on ole_pkg, ole_if, ole_ctrl and ole_datapath.
//
//   channel   dir   beat contents
//   req_bus   in    cmd, value, position
//   rsp_bus   out   status, removed_value, entry_count
//
// One command at a time. Push back, push front onto an empty list, unused codes
// and commands refused at dispatch go from the dispatch state to the done state;
// other front inserts and removals walk the entry memory one entry per cycle.
// Reset clears length, state and result valid; entries hold garbage until written.
// A result waits in its output register; the next command is accepted as soon
// as the previous result has been moved into that register.
module ordered_list_engine_top (
   input logic     clock,
   input logic     reset,
   ole_req_if.sink   req_bus,
   ole_rsp_if.source rsp_bus
);
   import ole_pkg::*;

   dp_cmd_type  dp_cmd;
   dp_stat_type dp_stat;

   ole_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .dp_cmd    (dp_cmd),
      .dp_stat   (dp_stat)
   );

   ole_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .req_cmd           (req_bus.cmd),
      .req_value         (req_bus.value),
      .req_position      (req_bus.position),
      .dp_cmd            (dp_cmd),
      .dp_stat           (dp_stat),
      .rsp_status        (rsp_bus.status),
      .rsp_removed_value (rsp_bus.removed_value),
      .rsp_entry_count   (rsp_bus.entry_count)
   );

endmodule

// ----- tb/list_checker.sv -----
// Checker for the ordered list engine: watches the command and result channels,
// keeps its own copy of the list and compares every result beat in order.
// Depends on ole_pkg and the channel interfaces in ole_if.
module list_checker (
   input  logic clock,
   input  logic reset,
   ole_req_if   req_mon,
   ole_rsp_if   rsp_mon,
   output int   fail_count,
   output int   outstanding
);
   import ole_pkg::*;

   typedef struct packed {
      logic [STATUS_W-1:0]       status;
      logic signed [VALUE_W-1:0] removed_value;
      logic [COUNT_W-1:0]        entry_count;
   } list_result_type;

   logic signed [VALUE_W-1:0] shadow_list [DEPTH];
   int                        shadow_len = 0;
   list_result_type           result_q [$];
   int                        errors = 0;

   // pull one entry out and close the gap behind it
   function automatic logic signed [VALUE_W-1:0] take_entry(input int idx);
      logic signed [VALUE_W-1:0] v;
      v = shadow_list[idx];
      for (int i = idx; i + 1 < shadow_len; i++)
         shadow_list[i] = shadow_list[i + 1];
      shadow_len--;
      return v;
   endfunction

   function automatic list_result_type apply_command(input logic [CMD_W-1:0] cmd,
                                                     input logic signed [VALUE_W-1:0] value,
                                                     input logic [POS_W-1:0] position);
      list_result_type r;
      int              hit;
      r.status        = STAT_OK;
      r.removed_value = '0;
      hit             = -1;
      case (cmd)
         CMD_PUSH_BACK: begin
            if (shadow_len >= DEPTH) begin
               r.status = STAT_FULL;
            end else begin
               shadow_list[shadow_len] = value;
               shadow_len++;
            end
         end
         CMD_PUSH_FRONT: begin
            if (shadow_len >= DEPTH) begin
               r.status = STAT_FULL;
            end else begin
               for (int i = shadow_len; i > 0; i--)
                  shadow_list[i] = shadow_list[i - 1];
               shadow_list[0] = value;
               shadow_len++;
            end
         end
         CMD_POP_BACK: begin
            if (shadow_len == 0) r.status = STAT_MISS;
            else r.removed_value = take_entry(shadow_len - 1);
         end
         CMD_POP_FRONT: begin
            if (shadow_len == 0) r.status = STAT_MISS;
            else r.removed_value = take_entry(0);
         end
         CMD_REMOVE_AT: begin
            if (int'(position) >= shadow_len) r.status = STAT_MISS;
            else r.removed_value = take_entry(int'(position));
         end
         CMD_REMOVE_VAL: begin
            // first match counted from the front
            for (int i = 0; i < shadow_len; i++) begin
               if (hit < 0 && shadow_list[i] == value) hit = i;
            end
            if (hit < 0) r.status = STAT_MISS;
            else r.removed_value = take_entry(hit);
         end
         default: ;  // unused codes leave the list alone
      endcase
      r.entry_count = COUNT_W'(shadow_len);
      return r;
   endfunction

   always @(posedge clock) begin
      list_result_type want;
      if (reset) begin
         shadow_len = 0;
         result_q.delete();
      end else begin
         // a result beat always belongs to an older command, so check it first
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (result_q.size() == 0) begin
               $error("result beat with no command outstanding");
               errors++;
            end else begin
               want = result_q.pop_front();
               if (rsp_mon.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_mon.status);
                  errors++;
               end
               if (rsp_mon.removed_value !== want.removed_value) begin
                  $error("removed_value: expected %0d, got %0d",
                         want.removed_value, rsp_mon.removed_value);
                  errors++;
               end
               if (rsp_mon.entry_count !== want.entry_count) begin
                  $error("entry_count: expected %0d, got %0d",
                         want.entry_count, rsp_mon.entry_count);
                  errors++;
               end
            end
         end
         if (req_mon.valid && req_mon.ready)
            result_q.push_back(apply_command(req_mon.cmd, req_mon.value, req_mon.position));
      end
      outstanding <= result_q.size();
      fail_count  <= errors;
   end

endmodule

// ----- tb/tb.sv -----
// Top of the ordered list engine testbench: clock, reset, command stimulus and
// result back-pressure. Depends on ole_pkg, ole_if, the engine and list_checker.
module tb;
   import ole_pkg::*;

   localparam int RANDOM_ITEMS = 1750;
   localparam int CYCLE_LIMIT  = 600000;
   localparam int LONG_HOLD    = 300;

   // codes the engine treats as no-ops
   localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
   localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

   logic clock;
   logic reset;
   int   fail_count;
   int   outstanding;
   int   burst_left = 0;
   int   hold_requests = 0;
   int   cycle_count = 0;

   ole_req_if req_bus ();
   ole_rsp_if rsp_bus ();

   ordered_list_engine_top u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   list_checker u_check (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_bus),
      .rsp_mon     (rsp_bus),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      forever begin
         @(posedge clock);
         cycle_count <= cycle_count + 1;
         if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   // result side: stall modes change every so often; a requested long hold
   // is counted here so the sender keeps pushing meanwhile
   initial begin
      int holds_done;
      int mode;
      int mode_left;
      int phase;
      holds_done = 0;
      mode       = 0;
      mode_left  = 0;
      phase      = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_requests != holds_done) begin
            holds_done++;
            rsp_bus.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end
         if (mode_left == 0) begin
            mode      = $urandom_range(0, 3);
            mode_left = $urandom_range(32, 200);
         end
         mode_left--;
         phase++;
         case (mode)
            0:       rsp_bus.ready <= 1'b1;
            1:       rsp_bus.ready <= 1'($urandom_range(0, 1));
            2:       rsp_bus.ready <= (phase % 4 == 0);
            default: rsp_bus.ready <= ($urandom_range(0, 4) != 0);
         endcase
      end
   end

   task automatic issue(input logic [CMD_W-1:0] c, input logic signed [VALUE_W-1:0] v,
                        input logic [POS_W-1:0] p);
      if (burst_left == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = ($urandom_range(0, 5) == 0) ? 60 : $urandom_range(1, 12);
      end
      req_bus.valid    <= 1'b1;
      req_bus.cmd      <= c;
      req_bus.value    <= v;
      req_bus.position <= p;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      burst_left--;
   endtask

   // hold the sender until every outstanding result is back
   task automatic drain_results();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      burst_left = $urandom_range(1, 12);
   endtask

   // small pool so value searches hit often, plus extremes and full-range noise
   function automatic logic signed [VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0:       return 32'sh7FFFFFFF;
         1:       return 32'sh80000000;
         2, 3:    return $urandom;
         default: return VALUE_W'($urandom_range(0, 5) - 2);
      endcase
   endfunction

   initial begin
      int push_pct;
      int segment_left;
      int roll;
      logic [CMD_W-1:0] c;
      push_pct     = 50;
      segment_left = 0;
      reset            <= 1'b1;
      req_bus.valid    <= 1'b0;
      req_bus.cmd      <= CMD_PUSH_BACK;
      req_bus.value    <= '0;
      req_bus.position <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // empty-list removals and unused codes
      issue(CMD_POP_BACK, 0, '0);
      issue(CMD_POP_FRONT, 0, '0);
      issue(CMD_REMOVE_AT, 0, '0);
      issue(CMD_REMOVE_VAL, 0, '0);
      issue(CMD_SPARE_LO, -1, 4'hF);
      issue(CMD_SPARE_HI, 32'sh7FFFFFFF, 4'hF);
      issue(CMD_PUSH_BACK, 32'sh7FFFFFFF, '0);
      issue(CMD_PUSH_FRONT, 32'sh80000000, '0);
      issue(CMD_REMOVE_VAL, 32'sh80000000, '0);  // match at the head
      issue(CMD_REMOVE_VAL, 12345, '0);          // not present
      issue(CMD_REMOVE_AT, 0, 4'd1);             // position past the length
      issue(CMD_POP_BACK, 0, '0);                // single entry empties the list
      for (int i = 0; i < DEPTH; i++)
         issue((i % 2) ? CMD_PUSH_FRONT : CMD_PUSH_BACK,
               (i == 3) ? -1 : (i == 5) ? 0 : VALUE_W'($urandom), '0);
      issue(CMD_PUSH_BACK, 1, '0);               // full
      issue(CMD_PUSH_FRONT, 2, '0);              // full
      issue(CMD_REMOVE_AT, 0, 4'd15);
      issue(CMD_REMOVE_AT, 0, 4'd0);
      drain_results();

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (segment_left == 0) begin
            case ($urandom_range(0, 2))
               0:       push_pct = 85;
               1:       push_pct = 50;
               default: push_pct = 25;
            endcase
            segment_left = $urandom_range(40, 100);
         end
         segment_left--;
         if (n == 500) hold_requests++;
         if (n == 1100) drain_results();
         roll = $urandom_range(0, 99);
         if (roll == 0)
            c = $urandom_range(0, 1) ? CMD_SPARE_HI : CMD_SPARE_LO;
         else if (roll <= push_pct)
            c = $urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
         else
            c = CMD_W'($urandom_range(CMD_POP_BACK, CMD_REMOVE_VAL));
         issue(c, pick_value(), POS_W'($urandom_range(0, 15)));
      end

      drain_results();
      repeat (40) @(posedge clock);
      if (fail_count == 0 && outstanding == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
